// File: hw/rtl/scrolling_text_lane_allocator_defines.svh
// Assertion macros used by the lane allocator RTL.
`ifndef SCROLLING_TEXT_LANE_ALLOCATOR_DEFINES_SVH
`define SCROLLING_TEXT_LANE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH

`define STLA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

`define STLA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`else

`define STLA_ASSERT_SAME(label, ante, cons)

`define STLA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/stla_pkg.sv
// Shared constants and types of the scrolling text lane allocator.
`default_nettype none

package stla_pkg;

   localparam int MAX_LANES = 16;
   localparam int LANE_W    = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
   localparam int CNT_W     = $clog2(MAX_LANES + 1);

   localparam int SCREEN_W  = 13;
   localparam int SHOW_W    = 16;
   localparam int LANES_W   = 5;
   localparam int START_W   = 32;
   localparam int TWIDTH_W  = 13;
   localparam int OUT_LANE_W = 4;
   localparam int ENTRY_W   = START_W + TWIDTH_W;

   localparam logic [SCREEN_W-1:0] SCREEN_RESET = 13'd1920;
   localparam logic [SHOW_W-1:0]   SHOW_RESET   = 16'd5000;
   localparam logic [LANES_W-1:0]  LANES_RESET  = 5'd10;

   typedef enum logic [1:0] {
      REG_SCREEN_WIDTH = 2'd0,
      REG_SHOW_TIME    = 2'd1,
      REG_LANES_IN_USE = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [SCREEN_W-1:0] screen_width;
      logic [SHOW_W-1:0]   show_time_ms;
      logic [LANES_W-1:0]  lanes_in_use;
   } cfg_type;

   // One lane's stored record together with the item being placed.
   typedef struct packed {
      logic                valid;
      logic [LANE_W-1:0]   lane;
      logic                used;
      logic [START_W-1:0]  last_start;
      logic [TWIDTH_W-1:0] last_width;
      logic [START_W-1:0]  new_start;
      logic [TWIDTH_W-1:0] new_width;
   } lane_req_type;

   typedef struct packed {
      logic              valid;
      logic              free;
      logic [LANE_W-1:0] lane;
   } check_type;

endpackage

`default_nettype wire

// File: hw/rtl/stla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module stla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/stla_csr.sv
// APB-style configuration registers of the lane allocator.
`default_nettype none

module stla_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output stla_pkg::cfg_type cfg
);

   stla_pkg::cfg_type        cfg_ff;
   stla_pkg::cfg_type        cfg_in;
   stla_pkg::reg_index_type  index;
   logic                     write_en;

   assign csr_pready = 1'b1;
   assign index      = stla_pkg::reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            stla_pkg::REG_SCREEN_WIDTH:
               cfg_in.screen_width = csr_pwdata[stla_pkg::SCREEN_W-1:0];
            stla_pkg::REG_SHOW_TIME:
               cfg_in.show_time_ms = csr_pwdata[stla_pkg::SHOW_W-1:0];
            stla_pkg::REG_LANES_IN_USE:
               cfg_in.lanes_in_use = csr_pwdata[stla_pkg::LANES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         stla_pkg::REG_SCREEN_WIDTH:
            csr_prdata = {{(32-stla_pkg::SCREEN_W){1'b0}}, cfg_ff.screen_width};
         stla_pkg::REG_SHOW_TIME:
            csr_prdata = {{(32-stla_pkg::SHOW_W){1'b0}}, cfg_ff.show_time_ms};
         stla_pkg::REG_LANES_IN_USE:
            csr_prdata = {{(32-stla_pkg::LANES_W){1'b0}}, cfg_ff.lanes_in_use};
         default:
            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width <= stla_pkg::SCREEN_RESET;
         cfg_ff.show_time_ms <= stla_pkg::SHOW_RESET;
         cfg_ff.lanes_in_use <= stla_pkg::LANES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: hw/rtl/stla_lane_check.sv
// Two-stage lane free test: products in the first stage, compare in the second.
`default_nettype none

module stla_lane_check (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   flush,
   input  wire stla_pkg::cfg_type      cfg,
   input  wire stla_pkg::lane_req_type req,
   output stla_pkg::check_type         result
);

   logic signed [32:0] elapsed;
   logic signed [14:0] speed_sum;
   logic signed [33:0] time_left;
   logic signed [13:0] width_gap;
   logic               quick_in;
   logic signed [47:0] lhs_in;
   logic        [28:0] bias_in;
   logic signed [47:0] rhs_in;

   logic                          valid_ff;
   logic [stla_pkg::LANE_W-1:0]   lane_ff;
   logic                          quick_ff;
   logic signed [47:0]            lhs_ff;
   logic        [28:0]            bias_ff;
   logic signed [47:0]            rhs_ff;

   logic signed [48:0]            margin;

   always_comb begin
      elapsed   = $signed({1'b0, req.new_start}) - $signed({1'b0, req.last_start});
      speed_sum = $signed({2'b00, cfg.screen_width} + {2'b00, req.last_width});
      time_left = $signed({18'd0, cfg.show_time_ms}) - $signed({elapsed[32], elapsed});
      width_gap = $signed({1'b0, req.new_width}) - $signed({1'b0, req.last_width});
      // Unused lane, last item gone, or the new item is no faster.
      quick_in  = !req.used
                  || (elapsed >= $signed({17'd0, cfg.show_time_ms}))
                  || (req.new_width <= req.last_width);
      lhs_in    = speed_sum * elapsed;
      bias_in   = req.last_width * cfg.show_time_ms;
      rhs_in    = time_left * width_gap;
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff  <= req.lane;
      quick_ff <= quick_in;
      lhs_ff   <= lhs_in;
      bias_ff  <= bias_in;
      rhs_ff   <= rhs_in;
   end

   // The products are only meaningful when the quick rules fail, where the
   // remaining time and the width gap are both positive.
   assign margin = $signed({lhs_ff[47], lhs_ff}) - $signed({20'd0, bias_ff});

   assign result.valid = valid_ff;
   assign result.lane  = lane_ff;
   assign result.free  = quick_ff
                         || (!margin[48] && (margin > $signed({rhs_ff[47], rhs_ff})));

endmodule

`default_nettype wire

// File: hw/rtl/scrolling_text_lane_allocator.sv
// One item at a time: a new item is taken only once the last result has entered the
// output register, so a stalled result holds off the next item.
// Lanes are examined in order from zero, up to the first free lane or the last lane in use.
// Reset: synchronous, active high; all lanes marked unused, registers to their defaults.
// No clearing pass: a lane's record counts only once its lane has been written; until then its used bit marks it free.
`default_nettype none
`include "scrolling_text_lane_allocator_defines.svh"

module scrolling_text_lane_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // [31:0] start_time_ms, [44:32] text_width
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,   // [0] placed, [4:1] lane_index
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   localparam int LW = stla_pkg::LANE_W;
   localparam int CW = stla_pkg::CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_HOLD   = 3'b100
   } state_type;

   stla_pkg::cfg_type       cfg;
   stla_pkg::lane_req_type  lane_req;
   stla_pkg::check_type     check;

   state_type                       state_ff, state_in;
   logic [stla_pkg::START_W-1:0]    start_ff, start_in;
   logic [stla_pkg::TWIDTH_W-1:0]   width_ff, width_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [CW-1:0]                   issue_ff, issue_in;
   logic                            rd_valid_ff, rd_valid_in;
   logic [LW-1:0]                   rd_lane_ff, rd_lane_in;
   logic [stla_pkg::MAX_LANES-1:0]  used_ff, used_in;
   logic                            hold_placed_ff, hold_placed_in;
   logic [LW-1:0]                   hold_lane_ff, hold_lane_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [7:0]                      rsp_data_ff, rsp_data_in;

   logic                            accept;
   logic [CW-1:0]                   count_sat;
   logic                            rd_en;
   logic                            done;
   logic                            wr_en;
   logic [stla_pkg::ENTRY_W-1:0]    rd_data;
   logic                            out_free;

   stla_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   stla_ram #(
      .WIDTH (stla_pkg::ENTRY_W),
      .DEPTH (stla_pkg::MAX_LANES)
   ) u_lane_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (check.lane),
      .wr_data ({start_ff, width_ff}),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[LW-1:0]),
      .rd_data (rd_data)
   );

   assign lane_req.valid      = rd_valid_ff;
   assign lane_req.lane       = rd_lane_ff;
   assign lane_req.used       = used_ff[rd_lane_ff];
   assign lane_req.last_start = rd_data[stla_pkg::ENTRY_W-1:stla_pkg::TWIDTH_W];
   assign lane_req.last_width = rd_data[stla_pkg::TWIDTH_W-1:0];
   assign lane_req.new_start  = start_ff;
   assign lane_req.new_width  = width_ff;

   stla_lane_check u_check (
      .clock  (clock),
      .reset  (reset),
      .flush  (done),
      .cfg    (cfg),
      .req    (lane_req),
      .result (check)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign count_sat = (32'(cfg.lanes_in_use) > 32'(stla_pkg::MAX_LANES))
                      ? CW'(stla_pkg::MAX_LANES) : CW'(cfg.lanes_in_use);

   // Results arrive in lane order, so a busy final lane means none is free.
   assign done  = (state_ff == ST_SEARCH) && check.valid
                  && (check.free || (CW'(check.lane) == count_ff - CW'(1)));
   assign wr_en = done && check.free;
   assign rd_en = (state_ff == ST_SEARCH) && (issue_ff < count_ff) && !done;

   always_comb begin
      state_in       = state_ff;
      start_in       = start_ff;
      width_in       = width_ff;
      count_in       = count_ff;
      issue_in       = issue_ff;
      rd_valid_in    = rd_en;
      rd_lane_in     = issue_ff[LW-1:0];
      used_in        = used_ff;
      hold_placed_in = hold_placed_ff;
      hold_lane_in   = hold_lane_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;

      if (wr_en) begin
         used_in[check.lane] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               start_in       = req_tdata[stla_pkg::START_W-1:0];
               width_in       = req_tdata[stla_pkg::START_W +: stla_pkg::TWIDTH_W];
               count_in       = count_sat;
               issue_in       = '0;
               hold_placed_in = 1'b0;
               hold_lane_in   = '0;
               state_in       = (count_sat == '0) ? ST_HOLD : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (rd_en) begin
               issue_in = issue_ff + CW'(1);
            end
            if (done) begin
               hold_placed_in = check.free;
               hold_lane_in   = check.free ? check.lane : '0;
               state_in       = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, stla_pkg::OUT_LANE_W'(hold_lane_ff), hold_placed_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff       <= start_in;
      width_ff       <= width_in;
      count_ff       <= count_in;
      issue_ff       <= issue_in;
      rd_lane_ff     <= rd_lane_in;
      hold_placed_ff <= hold_placed_in;
      hold_lane_ff   <= hold_lane_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `STLA_ASSERT_SAME(a_drop_gives_lane_zero, rsp_valid_ff && !rsp_data_ff[0], rsp_data_ff[4:1] == 4'd0)
   `STLA_ASSERT_NEXT(a_write_marks_used, wr_en, used_ff[$past(check.lane)])
   `STLA_ASSERT_SAME(a_check_within_count, (state_ff == ST_SEARCH) && check.valid, CW'(check.lane) < count_ff)
   `STLA_ASSERT_SAME(a_no_read_outside_search, rd_en, state_ff == ST_SEARCH)

endmodule

`default_nettype wire

// File: tb/tb_scrolling_text_lane_allocator.sv
// Self-checking testbench for the scrolling text lane allocator.
`default_nettype none

module tb_scrolling_text_lane_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [stla_pkg::START_W-1:0]  start;
      logic [stla_pkg::TWIDTH_W-1:0] width;
   } text_item_type;

   typedef struct packed {
      logic                            placed;
      logic [stla_pkg::OUT_LANE_W-1:0] lane;
   } lane_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // [31:0] start_time_ms, [44:32] text_width
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [0] placed, [4:1] lane_index
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   scrolling_text_lane_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Our own copy of the registers and of the lane records.
   logic [stla_pkg::SCREEN_W-1:0] cfg_screen = stla_pkg::SCREEN_RESET;
   logic [stla_pkg::SHOW_W-1:0]   cfg_show   = stla_pkg::SHOW_RESET;
   logic [stla_pkg::LANES_W-1:0]  cfg_lanes  = stla_pkg::LANES_RESET;
   logic                          lane_taken [stla_pkg::MAX_LANES];
   logic [stla_pkg::START_W-1:0]  lane_start [stla_pkg::MAX_LANES];
   logic [stla_pkg::TWIDTH_W-1:0] lane_width [stla_pkg::MAX_LANES];

   text_item_type   pending_texts[$];
   lane_result_type expected_lanes[$];
   text_item_type   on_offer;
   int unsigned     send_idle_pct = 0;
   int unsigned     stall_pct = 0;
   logic            long_hold = 1'b0;
   int unsigned     error_count = 0;
   logic [stla_pkg::START_W-1:0] scroll_clock = 32'd30000;

   initial begin
      for (int k = 0; k < stla_pkg::MAX_LANES; k++) begin
         lane_taken[k] = 1'b0;
         lane_start[k] = '0;
         lane_width[k] = '0;
      end
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Picks the lowest lane that the new item cannot catch up in, and records it there.
   function automatic lane_result_type allocate_lane(
         input logic [stla_pkg::START_W-1:0] tn,
         input logic [stla_pkg::TWIDTH_W-1:0] wn);
      lane_result_type r;
      int unsigned     count;
      int              k;
      logic            free;
      longint          w, d, wl, wnew, e, lhs;
      r = '0;
      count = (cfg_lanes > stla_pkg::MAX_LANES) ? stla_pkg::MAX_LANES : cfg_lanes;
      w = cfg_screen;
      d = cfg_show;
      wnew = wn;
      for (k = 0; k < count && !r.placed; k++) begin
         if (!lane_taken[k]) begin
            free = 1'b1;
         end else begin
            wl = lane_width[k];
            e = tn;
            e = e - longint'(lane_start[k]);
            lhs = (w + wl) * e;
            if (e >= d || wnew <= wl)
               free = 1'b1;
            else if (lhs < wl * d)
               free = 1'b0;
            else
               free = (lhs - wl * d) > (d - e) * (wnew - wl);
         end
         if (free) begin
            lane_taken[k] = 1'b1;
            lane_start[k] = tn;
            lane_width[k] = wn;
            r.placed = 1'b1;
            r.lane = k[stla_pkg::OUT_LANE_W-1:0];
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      // Keep the log readable when the design is badly broken.
      if (error_count < 100)
         $display("%0t ns: %s", $time, what);
      error_count++;
   endtask

   // Driver: offers queued items and predicts each one as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_lanes.push_back(allocate_lane(on_offer.start, on_offer.width));
         if (!req_tvalid || req_tready) begin
            if (pending_texts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_offer = pending_texts.pop_front();
               req_tdata <= {3'b000, on_offer.width, on_offer.start};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result that it takes against the oldest expectation.
   always @(posedge clock) begin
      lane_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_lanes.size() == 0) begin
               report_mismatch($sformatf("result 0x%02h with nothing expected", rsp_tdata));
            end else begin
               want = expected_lanes.pop_front();
               if (rsp_tdata[0] !== want.placed)
                  report_mismatch($sformatf("placed %b, expected %b",
                                            rsp_tdata[0], want.placed));
               if (rsp_tdata[4:1] !== want.lane)
                  report_mismatch($sformatf("lane_index %0d, expected %0d",
                                            rsp_tdata[4:1], want.lane));
            end
         end
         rsp_tready <= !long_hold && ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic queue_text(input logic [stla_pkg::START_W-1:0] start,
                             input logic [stla_pkg::TWIDTH_W-1:0] width);
      pending_texts.push_back('{start: start, width: width});
   endtask

   task automatic wait_until_idle();
      @(negedge clock);
      while (pending_texts.size() != 0 || req_tvalid || expected_lanes.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_register(input stla_pkg::reg_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         stla_pkg::REG_SCREEN_WIDTH: cfg_screen = value[stla_pkg::SCREEN_W-1:0];
         stla_pkg::REG_SHOW_TIME:    cfg_show   = value[stla_pkg::SHOW_W-1:0];
         stla_pkg::REG_LANES_IN_USE: cfg_lanes  = value[stla_pkg::LANES_W-1:0];
         default: ;
      endcase
   endtask

   // Registers change only once the block has drained and settled.
   task automatic set_geometry(input logic [31:0] w, input logic [31:0] d,
                               input logic [31:0] lanes);
      wait_until_idle();
      repeat (24) @(posedge clock);
      write_register(stla_pkg::REG_SCREEN_WIDTH, w);
      write_register(stla_pkg::REG_SHOW_TIME, d);
      write_register(stla_pkg::REG_LANES_IN_USE, lanes);
   endtask

   // Mostly a steadily advancing stream of captions, with some late ones and some noise.
   task automatic queue_random(input int unsigned n, input int unsigned send_pct,
                               input int unsigned stall);
      int unsigned   pick, step_max;
      text_item_type item;
      @(negedge clock);
      send_idle_pct = send_pct;
      stall_pct = stall;
      step_max = 32'(cfg_show >> 2) + 32'd2;
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            item.start = $urandom;
            item.width = stla_pkg::TWIDTH_W'($urandom);
         end else begin
            if (pick < 16) begin
               item.start = scroll_clock - $urandom_range(0, step_max);
            end else begin
               scroll_clock += $urandom_range(0, step_max);
               item.start = scroll_clock;
            end
            item.width = pick[0] ? stla_pkg::TWIDTH_W'($urandom_range(0, 8191))
                                 : stla_pkg::TWIDTH_W'($urandom_range(0, 400));
         end
         pending_texts.push_back(item);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset settings.
      queue_text(32'd0, 13'd0);
      queue_text(32'hFFFF_FFFF, 13'd8191);   // last item long gone
      queue_text(32'd1000, 13'd100);          // earlier start, but narrower
      queue_text(32'd900, 13'd200);           // earlier start and wider: lane 0 refused
      queue_text(32'd2000, 13'd150);          // wider, yet cannot catch up
      queue_text(32'd2100, 13'd8000);         // would catch up in lanes 0 and 1
      queue_text(32'd5900, 13'd8191);         // elapsed time exactly the show time
      // Ever wider items at one instant fill every lane in use, then the last two are dropped.
      for (int i = 1; i <= 12; i++)
         queue_text(32'd20000, 13'(i * 100));
      queue_random(280, 0, 0);

      set_geometry(32'd8191, 32'd65535, 32'd16);
      queue_random(300, 74, 0);

      set_geometry(32'd1, 32'd1, 32'd1);
      queue_random(300, 0, 74);

      // Zero width and zero show time are used as they are; the lane count saturates.
      set_geometry(32'd0, 32'd0, 32'd31);
      queue_random(300, 11, 11);

      // No lane searched: every item is dropped. The unused index must change nothing.
      set_geometry(32'd640, 32'd3000, 32'd0);
      write_register(stla_pkg::REG_UNUSED, 32'hFFFF_FFFF);
      queue_random(40, 0, 0);

      // Over-wide writes are truncated; the stream wraps past the top of the time range.
      set_geometry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      scroll_clock = 32'hFFF0_0000;
      @(negedge clock);
      long_hold <= 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            long_hold <= 1'b0;
         end
      join_none
      queue_random(340, 0, 0);

      set_geometry(32'd1920, 32'd5000, 32'd10);
      queue_random(190, 74, 74);
      wait_until_idle();
      queue_random(190, 74, 74);

      wait_until_idle();
      repeat (24) @(posedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

// File: scrolling_text_lane_allocator.f
+incdir+hw/rtl
hw/rtl/stla_pkg.sv
hw/rtl/stla_ram.sv
hw/rtl/stla_csr.sv
hw/rtl/stla_lane_check.sv
hw/rtl/scrolling_text_lane_allocator.sv
tb/tb_scrolling_text_lane_allocator.sv
